[rtl/frht_pkg.sv]
// Shared types and constants for the flood relay history table
package frht_pkg;

    localparam int HIST_DEPTH_DEF = 32;

    localparam logic signed [7:0] SNR_THRESHOLD_RST = -8'sd5;
    localparam logic [15:0] RELAY_DELAY_RST = 16'd500;
    localparam logic [15:0] RETRY_DELAY_RST = 16'd50;

    localparam logic [1:0] OP_RECEIVE = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_REJECT  = 2'd2;
    localparam logic [1:0] OP_UNDEF   = 2'd3;

    localparam logic [1:0] ST_RECEIVED = 2'd0;
    localparam logic [1:0] ST_PENDING  = 2'd1;
    localparam logic [1:0] ST_RELAYED  = 2'd2;
    localparam logic [1:0] ST_CANCELED = 2'd3;

    localparam logic [1:0] REG_SNR_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_RELAY_DELAY   = 2'd1;
    localparam logic [1:0] REG_RETRY_DELAY   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_OUT,
        S_INS,
        S_REJ
    } state_t;

    typedef struct packed {
        logic load;      // capture input transaction, start at head
        logic rd;        // read entry at scan index
        logic advance;   // step scan index
        logic insert;    // write new entry at tail
        logic cancel;    // duplicate cancels pending relay if its snr beats the stored one and the threshold
        logic tick_upd;  // apply tick update to scanned entry
        logic reject;    // apply reject re-arm
        logic emit;      // load output register
        logic emit_new;
    } cmd_t;

    typedef struct packed {
        logic op_rx;
        logic op_tick;
        logic op_rej;
        logic scan_end;     // scan index reached tail
        logic flush_hold;   // final tick request waits for the output register
        logic hit;          // receive: crc matches
        logic tick_emit;    // tick: entry due and relayable
        logic out_busy;     // output register holds a transaction under stall
    } stat_t;

endpackage

[rtl/frht_ctrl.sv]
// Controller state machine for the flood relay history table
module frht_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  frht_pkg::stat_t  st,
    output frht_pkg::cmd_t   cmd,
    output logic             busy
);

    frht_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= frht_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            frht_pkg::S_IDLE:
                if (in_fire) state_next = frht_pkg::S_RD;
            frht_pkg::S_RD:
                priority if (st.op_rej) state_next = frht_pkg::S_REJ;
                else if (!st.op_rx && !st.op_tick) state_next = frht_pkg::S_IDLE;
                else if (st.scan_end)
                begin
                    if (st.op_rx)
                        state_next = frht_pkg::S_INS;
                    else if (!st.flush_hold)
                        state_next = frht_pkg::S_IDLE;
                end
                else state_next = frht_pkg::S_CHK;
            frht_pkg::S_CHK:
                priority if (st.op_rx && st.hit) state_next = frht_pkg::S_OUT;
                else if (st.op_tick && st.tick_emit) state_next = frht_pkg::S_OUT;
                else state_next = frht_pkg::S_RD;
            frht_pkg::S_OUT:
                if (!st.out_busy)
                    state_next = st.op_rx ? frht_pkg::S_IDLE : frht_pkg::S_RD;
            frht_pkg::S_INS:
                if (!st.out_busy) state_next = frht_pkg::S_IDLE;
            frht_pkg::S_REJ:
                state_next = frht_pkg::S_IDLE;
            default:
                state_next = frht_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = 1'b1;
        unique case (state_reg)
            frht_pkg::S_IDLE:
            begin
                busy = 1'b0;
                cmd.load = in_fire;
            end
            frht_pkg::S_RD:
                cmd.rd = 1'b1;
            frht_pkg::S_CHK:
            begin
                // tick entries not emitted are updated and skipped here
                if (st.op_tick && !st.tick_emit)
                begin
                    cmd.tick_upd = 1'b1;
                    cmd.advance = 1'b1;
                end
                if (st.op_rx && !st.hit)
                    cmd.advance = 1'b1;
            end
            frht_pkg::S_OUT:
                if (!st.out_busy)
                begin
                    cmd.emit = 1'b1;
                    if (st.op_rx)
                        cmd.cancel = 1'b1;
                    else
                    begin
                        cmd.tick_upd = 1'b1;
                        cmd.advance = 1'b1;
                    end
                end
            frht_pkg::S_INS:
                if (!st.out_busy)
                begin
                    cmd.insert = 1'b1;
                    cmd.emit = 1'b1;
                    cmd.emit_new = 1'b1;
                end
            frht_pkg::S_REJ:
                cmd.reject = 1'b1;
            default:
                cmd = '0;
        endcase
    end

endmodule

[rtl/frht_dp.sv]
// Datapath: ring memory, scan pointer, config registers and output register
module frht_dp #(
    parameter int HIST_DEPTH = frht_pkg::HIST_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  frht_pkg::cmd_t     cmd,
    output frht_pkg::stat_t    st,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [1:0]         op,
    input  logic [31:0]        now,
    input  logic [31:0]        packet_crc,
    input  logic signed [7:0]  packet_snr,
    input  logic               has_ttl,
    input  logic [7:0]         ttl_in,
    input  logic               for_me,
    input  logic [4:0]         reject_slot,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic               is_new,
    output logic [4:0]         slot,
    output logic [31:0]        entry_crc_out,
    output logic [7:0]         ttl_out,
    output logic               last
);

    localparam int AW = $clog2(HIST_DEPTH);

    // entry: crc, snr, status, due, ttl, has_ttl
    typedef struct packed {
        logic [31:0]       crc;
        logic signed [7:0] snr;
        logic [1:0]        status;
        logic [31:0]       due;
        logic [7:0]        ttl;
        logic              hv;
    } entry_t;

    entry_t mem [HIST_DEPTH];
    entry_t rd_reg;

    logic signed [7:0] thr_reg;
    logic [15:0] relay_reg, retry_reg;
    logic [AW-1:0] head_reg, tail_reg, idx_reg, idx_next;
    logic [1:0] op_reg;
    logic [31:0] now_reg, crc_reg;
    logic signed [7:0] snr_reg;
    logic hv_reg, me_reg;
    logic [7:0] ttl_reg;
    logic [4:0] rslot_reg;
    logic [AW-1:0] rej_idx;
    logic rej_in_range, rej_live;
    logic [AW-1:0] off, cnt, tail_next;
    logic relayable;

    // whether the ring after the current entry holds another emit: a lookahead is
    // costly, so each tick result is held until the next one or scan end sets last
    logic ov_reg, kind_reg, new_reg, last_reg;
    logic [4:0] slot_reg;
    logic [31:0] ocrc_reg;
    logic [7:0] ottl_reg;
    logic pend_reg; // tick emit held until the next one or scan end

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] i);
        logic [AW-1:0] r;
        begin
            if (i == AW'(HIST_DEPTH - 1)) r = '0;
            else r = i + 1'b1;
            return r;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= frht_pkg::SNR_THRESHOLD_RST;
            relay_reg <= frht_pkg::RELAY_DELAY_RST;
            retry_reg <= frht_pkg::RETRY_DELAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                frht_pkg::REG_SNR_THRESHOLD: thr_reg <= cfg_data[7:0];
                frht_pkg::REG_RELAY_DELAY:   relay_reg <= cfg_data;
                frht_pkg::REG_RETRY_DELAY:   retry_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            now_reg <= now;
            crc_reg <= packet_crc;
            snr_reg <= packet_snr;
            hv_reg <= has_ttl;
            ttl_reg <= ttl_in;
            me_reg <= for_me;
            rslot_reg <= reject_slot;
        end
    end

    assign idx_next = cmd.load ? head_reg : (cmd.advance ? inc(idx_reg) : idx_reg);

    assign tail_next = inc(tail_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.insert)
            begin
                tail_reg <= tail_next;
                if (tail_next == head_reg) head_reg <= inc(head_reg);
            end
        end
    end

    logic [31:0] diff;
    assign diff = now_reg - rd_reg.due;
    assign relayable = rd_reg.hv && (rd_reg.ttl != 8'd0);

    assign rej_in_range = ({4'b0000, rslot_reg} < 9'(HIST_DEPTH));
    assign rej_idx = AW'(rslot_reg);
    assign off = rej_idx - head_reg + ((rej_idx < head_reg) ? AW'(HIST_DEPTH) : AW'(0));
    assign cnt = tail_reg - head_reg + ((tail_reg < head_reg) ? AW'(HIST_DEPTH) : AW'(0));
    assign rej_live = rej_in_range && (off < cnt);

    logic tick_hit;
    assign tick_hit = (rd_reg.status == frht_pkg::ST_PENDING) && !diff[31];

    entry_t wr_entry;
    logic [AW-1:0] wr_addr;
    logic wr_en;

    always_comb
    begin
        wr_entry = rd_reg;
        wr_addr = idx_reg;
        wr_en = 1'b0;
        priority if (cmd.insert)
        begin
            wr_addr = tail_reg;
            wr_en = 1'b1;
            wr_entry.crc = crc_reg;
            wr_entry.snr = snr_reg;
            wr_entry.ttl = ttl_reg;
            wr_entry.hv = hv_reg;
            if (hv_reg && ttl_reg != 8'd0 && !me_reg)
            begin
                wr_entry.status = frht_pkg::ST_PENDING;
                wr_entry.due = now_reg + {16'd0, relay_reg};
            end
            else
            begin
                wr_entry.status = frht_pkg::ST_RECEIVED;
                wr_entry.due = '0;
            end
        end
        else if (cmd.cancel)
        begin
            if (rd_reg.status == frht_pkg::ST_PENDING && snr_reg > rd_reg.snr
                && snr_reg > thr_reg)
            begin
                wr_en = 1'b1;
                wr_entry.status = frht_pkg::ST_CANCELED;
                wr_entry.due = '0;
            end
        end
        else if (cmd.tick_upd)
        begin
            if (tick_hit)
            begin
                wr_en = 1'b1;
                if (relayable)
                begin
                    wr_entry.status = frht_pkg::ST_RELAYED;
                    wr_entry.due = '0;
                end
                else
                    wr_entry.status = frht_pkg::ST_CANCELED;
            end
        end
        else if (cmd.reject)
        begin
            wr_addr = rej_idx;
            if (rej_live && rd_reg.status == frht_pkg::ST_RELAYED)
            begin
                wr_en = 1'b1;
                wr_entry.status = frht_pkg::ST_PENDING;
                wr_entry.due = now_reg + {16'd0, retry_reg};
            end
        end
    end

    logic [AW-1:0] rd_addr;
    assign rd_addr = (op_reg == frht_pkg::OP_REJECT) ? rej_idx : idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wr_addr] <= wr_entry;
        if (cmd.rd) rd_reg <= mem[rd_addr];
    end

    // tick results are held one step so the final one can carry last
    logic [4:0] pslot_reg;
    logic [31:0] pcrc_reg;
    logic [7:0] pttl_reg;
    logic out_busy;
    logic flush;
    assign out_busy = ov_reg && out_stall;
    assign flush = pend_reg && (op_reg == frht_pkg::OP_TICK) && cmd.rd && (idx_reg == tail_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit && op_reg == frht_pkg::OP_TICK)
            begin
                ov_reg <= pend_reg;
                pend_reg <= 1'b1;
            end
            else if (cmd.emit)
                ov_reg <= 1'b1;
            else if (flush && !out_busy)
            begin
                ov_reg <= 1'b1;
                pend_reg <= 1'b0;
            end
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit && op_reg == frht_pkg::OP_TICK)
        begin
            pslot_reg <= 5'(idx_reg);
            pcrc_reg <= rd_reg.crc;
            pttl_reg <= rd_reg.ttl - 8'd1;
            if (pend_reg)
            begin
                kind_reg <= 1'b1;
                new_reg <= 1'b0;
                slot_reg <= pslot_reg;
                ocrc_reg <= pcrc_reg;
                ottl_reg <= pttl_reg;
                last_reg <= 1'b0;
            end
        end
        else if (cmd.emit)
        begin
            kind_reg <= 1'b0;
            new_reg <= cmd.emit_new;
            slot_reg <= cmd.emit_new ? 5'(tail_reg) : 5'(idx_reg);
            ocrc_reg <= crc_reg;
            ottl_reg <= 8'd0;
            last_reg <= 1'b1;
        end
        else if (flush && !out_busy)
        begin
            kind_reg <= 1'b1;
            new_reg <= 1'b0;
            slot_reg <= pslot_reg;
            ocrc_reg <= pcrc_reg;
            ottl_reg <= pttl_reg;
            last_reg <= 1'b1;
        end
    end

    always_comb
    begin
        st.op_rx = (op_reg == frht_pkg::OP_RECEIVE);
        st.op_tick = (op_reg == frht_pkg::OP_TICK);
        st.op_rej = (op_reg == frht_pkg::OP_REJECT);
        st.scan_end = (idx_reg == tail_reg);
        st.flush_hold = flush && out_busy;
        st.hit = (rd_reg.crc == crc_reg);
        st.tick_emit = tick_hit && relayable;
        st.out_busy = out_busy;
    end

    assign out_valid = ov_reg;
    assign kind = kind_reg;
    assign is_new = new_reg;
    assign slot = slot_reg;
    assign entry_crc_out = ocrc_reg;
    assign ttl_out = ottl_reg;
    assign last = last_reg;

endmodule

[rtl/flood_relay_history_table_core.sv]
// Top level of the flood relay history table
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | op now packet_crc packet_snr has_ttl ttl_in for_me reject_slot
//  out     | out_valid | out_stall | kind is_new slot entry_crc_out ttl_out last
// Receive: each live entry from head to tail is read and then checked, up to a duplicate;
// a new packet is then inserted at the tail. Tick: every live entry is read and checked,
// and a relay request is issued for each due, relayable one. Reject and unknown ops read once.
// Read and check are separate states because the ring memory read port is registered.
// Reset clears pointers and config; no clearing pass. One transaction at a time;
// a stalled output holds the scan.
module flood_relay_history_table_core #(
    parameter int HIST_DEPTH = frht_pkg::HIST_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [31:0]        now,
    input  logic [31:0]        packet_crc,
    input  logic signed [7:0]  packet_snr,
    input  logic               has_ttl,
    input  logic [7:0]         ttl_in,
    input  logic               for_me,
    input  logic [4:0]         reject_slot,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic               is_new,
    output logic [4:0]         slot,
    output logic [31:0]        entry_crc_out,
    output logic [7:0]         ttl_out,
    output logic               last
);

    frht_pkg::cmd_t cmd;
    frht_pkg::stat_t st;
    logic busy;

    assign in_stall = busy;

    frht_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_valid && !busy),
        .st(st), .cmd(cmd), .busy(busy)
    );

    frht_dp #(.HIST_DEPTH(HIST_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .op(op), .now(now), .packet_crc(packet_crc), .packet_snr(packet_snr),
        .has_ttl(has_ttl), .ttl_in(ttl_in), .for_me(for_me), .reject_slot(reject_slot),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .is_new(is_new),
        .slot(slot), .entry_crc_out(entry_crc_out), .ttl_out(ttl_out), .last(last)
    );

endmodule

[rtl/frht_checker.sv]
// Port checker for the flood relay history table
module frht_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       kind,
    input logic       is_new,
    input logic [7:0] ttl_out,
    input logic       last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output dropped under stall");

    a_rx_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !kind |-> last && ttl_out == 8'd0)
        else $error("receive report malformed");

    a_req_old: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind |-> !is_new)
        else $error("relay request flagged new");

    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted while working");

endmodule

bind flood_relay_history_table_core frht_checker u_frht_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .is_new(is_new), .ttl_out(ttl_out), .last(last)
);

[test/testbench.sv]
// Self-checking testbench for the flood relay history table core
typedef struct {
    logic [1:0]        op;
    logic [31:0]       now;
    logic [31:0]       crc;
    logic signed [7:0] snr;
    logic              has_ttl;
    logic [7:0]        ttl;
    logic              for_me;
    logic [4:0]        rslot;
} relay_item_t;

typedef struct packed {
    logic        kind;
    logic        is_new;
    logic [4:0]  slot;
    logic [31:0] crc;
    logic [7:0]  ttl;
    logic        last;
} relay_report_t;

class relay_ledger;
    logic [31:0]       crc_mem [32];
    logic signed [7:0] orig_snr [32];
    logic [1:0]        status [32];
    logic [31:0]       due [32];
    logic [7:0]        ttl_mem [32];
    logic              has_ttl_mem [32];
    int                head;
    int                tail;
    logic signed [7:0] thr;
    logic [15:0]       relay_dly;
    logic [15:0]       retry_dly;
    relay_report_t     awaited [$];
    int                relayed_slots [$];
    int                errors;
    int                mismatches;
    int                checked;
    int                relays_seen;
    int                items;

    function new();
        head = 0;
        tail = 0;
        thr = frht_pkg::SNR_THRESHOLD_RST;
        relay_dly = frht_pkg::RELAY_DELAY_RST;
        retry_dly = frht_pkg::RETRY_DELAY_RST;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
        case (idx)
            frht_pkg::REG_SNR_THRESHOLD: thr = val[7:0];
            frht_pkg::REG_RELAY_DELAY:   relay_dly = val;
            frht_pkg::REG_RETRY_DELAY:   retry_dly = val;
            default: ;
        endcase
    endfunction

    function void add(logic k, logic n, int s, logic [31:0] c, logic [7:0] t);
        relay_report_t r;
        r.kind = k;
        r.is_new = n;
        r.slot = s[4:0];
        r.crc = c;
        r.ttl = t;
        r.last = 1'b1;
        awaited.push_back(r);
    endfunction

    // predict the reports caused by one accepted transaction
    function void note_input(relay_item_t it);
        int i;
        int s;
        int n;
        items++;
        case (it.op)
            frht_pkg::OP_RECEIVE:
            begin
                for (i = head; i != tail; i = (i + 1) % 32)
                begin
                    if (crc_mem[i] == it.crc)
                    begin
                        if (status[i] == frht_pkg::ST_PENDING && it.snr > orig_snr[i]
                            && it.snr > thr)
                        begin
                            status[i] = frht_pkg::ST_CANCELED;
                            due[i] = '0;
                        end
                        add(1'b0, 1'b0, i, it.crc, 8'd0);
                        return;
                    end
                end
                s = tail;
                crc_mem[s] = it.crc;
                orig_snr[s] = it.snr;
                status[s] = frht_pkg::ST_RECEIVED;
                due[s] = '0;
                ttl_mem[s] = it.ttl;
                has_ttl_mem[s] = it.has_ttl;
                tail = (tail + 1) % 32;
                if (tail == head)
                    head = (head + 1) % 32;
                if (it.has_ttl && it.ttl != 0 && !it.for_me)
                begin
                    status[s] = frht_pkg::ST_PENDING;
                    due[s] = it.now + 32'(relay_dly);
                end
                add(1'b0, 1'b1, s, it.crc, 8'd0);
            end
            frht_pkg::OP_TICK:
            begin
                n = 0;
                for (i = head; i != tail; i = (i + 1) % 32)
                begin
                    logic [31:0] diff;
                    diff = it.now - due[i];
                    if (status[i] != frht_pkg::ST_PENDING || diff[31])
                        continue;
                    if (!has_ttl_mem[i] || ttl_mem[i] == 0)
                    begin
                        status[i] = frht_pkg::ST_CANCELED;
                        continue;
                    end
                    status[i] = frht_pkg::ST_RELAYED;
                    due[i] = '0;
                    add(1'b1, 1'b0, i, crc_mem[i], ttl_mem[i] - 8'd1);
                    awaited[$].last = 1'b0;
                    relayed_slots.push_back(i);
                    n++;
                end
                if (n > 0)
                    awaited[$].last = 1'b1;
            end
            frht_pkg::OP_REJECT:
            begin
                s = it.rslot;
                if (((s + 32 - head) % 32) < ((tail + 32 - head) % 32)
                    && status[s] == frht_pkg::ST_RELAYED)
                begin
                    status[s] = frht_pkg::ST_PENDING;
                    due[s] = it.now + 32'(retry_dly);
                end
            end
            default: ;
        endcase
    endfunction

    function void check_result(relay_report_t got);
        relay_report_t want;
        checked++;
        if (got.kind)
            relays_seen++;
        if (awaited.size() == 0)
        begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected report: kind=%0d slot=%0d crc=%h",
                    got.kind, got.slot, got.crc);
            return;
        end
        want = awaited.pop_front();
        if (got !== want)
        begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp k=%0d n=%0d s=%0d c=%h t=%0d l=%0d, %s",
                    want.kind, want.is_new, want.slot, want.crc, want.ttl, want.last,
                    $sformatf("got k=%0d n=%0d s=%0d c=%h t=%0d l=%0d",
                        got.kind, got.is_new, got.slot, got.crc, got.ttl, got.last));
        end
    endfunction
endclass

module testbench;
    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [15:0]       cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        op;
    logic [31:0]       now;
    logic [31:0]       packet_crc;
    logic signed [7:0] packet_snr;
    logic              has_ttl;
    logic [7:0]        ttl_in;
    logic              for_me;
    logic [4:0]        reject_slot;
    logic              out_valid;
    logic              out_stall;
    logic              kind;
    logic              is_new;
    logic [4:0]        slot;
    logic [31:0]       entry_crc_out;
    logic [7:0]        ttl_out;
    logic              last;

    relay_ledger ledger;
    logic [31:0] clock_ms;
    logic [31:0] crc_pool [48];
    bit          hold_req;
    bit          hold_done;
    int          hold_left;
    int          pattern_cnt;
    int          stall_mode;

    flood_relay_history_table_core u_top (.*);

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #20000000;
        $display("testbench NOT OK");
        $finish;
    end

    // receiver: check reports and stall on a pattern of its own
    always @(posedge clk)
    begin
        relay_report_t r;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                r.kind = kind;
                r.is_new = is_new;
                r.slot = slot;
                r.crc = entry_crc_out;
                r.ttl = ttl_out;
                r.last = last;
                ledger.check_result(r);
            end
            if (hold_req && !hold_done)
            begin
                hold_left = 400;
                hold_done = 1;
            end
            pattern_cnt++;
            if (pattern_cnt % 50 == 0)
                stall_mode = $urandom_range(0, 2);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_mode == 0)
                out_stall <= 1'b0;
            else if (stall_mode == 1)
                out_stall <= ($urandom_range(0, 3) == 0);
            else
                out_stall <= ($urandom_range(0, 3) != 0);
        end
        else
            out_stall <= 1'b0;
    end

    task automatic offer(input relay_item_t it);
        in_valid <= 1'b1;
        op <= it.op;
        now <= it.now;
        packet_crc <= it.crc;
        packet_snr <= it.snr;
        has_ttl <= it.has_ttl;
        ttl_in <= it.ttl;
        for_me <= it.for_me;
        reject_slot <= it.rslot;
        do @(posedge clk); while (in_stall);
        ledger.note_input(it);
    endtask

    task automatic pause(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // wait out all reports, then let a transaction with no report finish
    task automatic drain();
        in_valid <= 1'b0;
        while (ledger.awaited.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        ledger.set_reg(idx, val);
    endtask

    function automatic relay_item_t mk(logic [1:0] o, logic [31:0] c, int s, logic h,
                                       logic [7:0] t, logic m, logic [4:0] rs);
        relay_item_t it;
        it.op = o;
        it.now = clock_ms;
        it.crc = c;
        it.snr = 8'(s);
        it.has_ttl = h;
        it.ttl = t;
        it.for_me = m;
        it.rslot = rs;
        return it;
    endfunction

    function automatic relay_item_t random_item();
        relay_item_t it;
        int pick;
        int step;
        step = $urandom_range(0, (int'(ledger.relay_dly) >> 3) + 40);
        if ($urandom_range(0, 99) == 0)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + step;
        it = mk(frht_pkg::OP_RECEIVE, $urandom, $urandom_range(0, 255),
                $urandom_range(0, 4) != 0, 8'($urandom_range(1, 255)),
                $urandom_range(0, 6) == 0, 5'($urandom_range(0, 31)));
        if ($urandom_range(0, 9) == 0)
            it.ttl = 8'd0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            if ($urandom_range(0, 9) < 7)
                it.crc = crc_pool[$urandom_range(0, 47)];
        end
        else if (pick < 85)
            it.op = frht_pkg::OP_TICK;
        else if (pick < 97)
        begin
            it.op = frht_pkg::OP_REJECT;
            if (ledger.relayed_slots.size() > 0 && $urandom_range(0, 9) < 6)
                it.rslot = 5'(ledger.relayed_slots[
                    $urandom_range(0, ledger.relayed_slots.size() - 1)]);
        end
        else
            it.op = frht_pkg::OP_UNDEF;
        return it;
    endfunction

    task automatic random_phase(input int count, input bit gaps);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                offer(random_item());
                sent++;
            end
            if (gaps && $urandom_range(0, 2) != 0)
                pause($urandom_range(1, 30));
        end
    endtask

    initial
    begin
        logic [15:0] ph_thr;
        logic [15:0] ph_rd;
        logic [15:0] ph_rt;
        int ph;
        ledger = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = frht_pkg::REG_SNR_THRESHOLD;
        cfg_data = '0;
        in_valid = 1'b0;
        op = frht_pkg::OP_RECEIVE;
        now = '0;
        packet_crc = '0;
        packet_snr = '0;
        has_ttl = 1'b0;
        ttl_in = '0;
        for_me = 1'b0;
        reject_slot = '0;
        foreach (crc_pool[i])
            crc_pool[i] = $urandom;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, cancel rules, relay, re-arm, ignored codes
        clock_ms = 32'd1000;
        offer(mk(frht_pkg::OP_RECEIVE, 32'h0, -128, 1'b1, 8'd255, 1'b0, 5'd0));
        offer(mk(frht_pkg::OP_RECEIVE, 32'hFFFF_FFFF, 127, 1'b1, 8'd1, 1'b0, 5'd0));
        offer(mk(frht_pkg::OP_RECEIVE, 32'h1234, 0, 1'b0, 8'd7, 1'b0, 5'd0));
        offer(mk(frht_pkg::OP_RECEIVE, 32'h5678, 0, 1'b1, 8'd0, 1'b0, 5'd0));
        offer(mk(frht_pkg::OP_RECEIVE, 32'h9ABC, 0, 1'b1, 8'd9, 1'b1, 5'd0));
        offer(mk(frht_pkg::OP_RECEIVE, 32'h0, -10, 1'b1, 8'd5, 1'b0, 5'd0));
        offer(mk(frht_pkg::OP_RECEIVE, 32'hFFFF_FFFF, 127, 1'b1, 8'd5, 1'b0, 5'd0));
        offer(mk(frht_pkg::OP_RECEIVE, 32'hA5A5_A5A5, 0, 1'b1, 8'd3, 1'b0, 5'd0));
        offer(mk(frht_pkg::OP_RECEIVE, 32'hA5A5_A5A5, 10, 1'b1, 8'd3, 1'b0, 5'd0));
        clock_ms = 32'd1200;
        offer(mk(frht_pkg::OP_TICK, 32'd0, 0, 1'b0, 8'd0, 1'b0, 5'd0));
        clock_ms = 32'd1500;
        offer(mk(frht_pkg::OP_TICK, 32'd0, 0, 1'b0, 8'd0, 1'b0, 5'd0));
        clock_ms = 32'd1510;
        offer(mk(frht_pkg::OP_REJECT, 32'd0, 0, 1'b0, 8'd0, 1'b0, 5'd0));
        offer(mk(frht_pkg::OP_REJECT, 32'd0, 0, 1'b0, 8'd0, 1'b0, 5'd3));
        offer(mk(frht_pkg::OP_REJECT, 32'd0, 0, 1'b0, 8'd0, 1'b0, 5'd31));
        offer(mk(frht_pkg::OP_UNDEF, 32'hFFFF_FFFF, -1, 1'b1, 8'hFF, 1'b1, 5'd31));
        clock_ms = 32'd1560;
        offer(mk(frht_pkg::OP_TICK, 32'd0, 0, 1'b0, 8'd0, 1'b0, 5'd0));
        offer(mk(frht_pkg::OP_RECEIVE, 32'h0, 127, 1'b1, 8'd5, 1'b0, 5'd0));
        drain();

        // settings: reset values, low extremes, high extremes, then random
        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    ph_thr = 16'(frht_pkg::SNR_THRESHOLD_RST);
                    ph_rd = 16'd500;
                    ph_rt = 16'd50;
                end
                1:
                begin
                    ph_thr = 16'h0080;
                    ph_rd = 16'd0;
                    ph_rt = 16'd0;
                end
                2:
                begin
                    ph_thr = 16'h007F;
                    ph_rd = 16'hFFFF;
                    ph_rt = 16'hFFFF;
                end
                default:
                begin
                    ph_thr = 16'($urandom_range(0, 255));
                    ph_rd = 16'($urandom_range(0, 2000));
                    ph_rt = 16'($urandom_range(0, 65535));
                end
            endcase
            write_reg(frht_pkg::REG_SNR_THRESHOLD, ph_thr);
            write_reg(frht_pkg::REG_RELAY_DELAY, ph_rd);
            write_reg(frht_pkg::REG_RETRY_DELAY, ph_rt);
            cfg_we <= 1'b0;
            if (ph == 3)
                clock_ms = 32'hFFFF_F000;
            if (ph == 4)
            begin
                // long receiver hold while items keep coming
                hold_req = 1;
                random_phase(20, 0);
            end
            random_phase(60, 1);
            drain();
        end

        $display("covered %0d transactions, %0d reports checked, %0d relay requests",
            ledger.items, ledger.checked, ledger.relays_seen);
        if (ledger.awaited.size() != 0)
            ledger.errors++;
        if (ledger.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
